// ----- rtl/xebs_pkg.sv -----
package xebs_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int POS_WIDTH   = 24;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int OPEN_W      = 9;
    localparam int OPEN_MAX    = 511;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    localparam logic [1:0] EV_NONE       = 2'd0;
    localparam logic [1:0] EV_OPEN       = 2'd1;
    localparam logic [1:0] EV_END_TAG    = 2'd2;
    localparam logic [1:0] EV_SELF_CLOSE = 2'd3;

    typedef enum logic [10:0] {
        PH_INIT    = 11'b000_0000_0001,
        PH_INIT_LT = 11'b000_0000_0010,
        PH_HEADER  = 11'b000_0000_0100,
        PH_BANG1   = 11'b000_0000_1000,
        PH_BANG2   = 11'b000_0001_0000,
        PH_COM0    = 11'b000_0010_0000,
        PH_COM1    = 11'b000_0100_0000,
        PH_COM2    = 11'b000_1000_0000,
        PH_OUT     = 11'b001_0000_0000,
        PH_OUT_LT  = 11'b010_0000_0000,
        PH_TAG     = 11'b100_0000_0000
    } phase_t;

    // one classified byte, handed from the front to the back
    typedef struct packed {
        logic                 decide;
        logic                 opens;
        logic                 gt;
        logic                 also;
        logic                 ferr;
        logic                 last;
        logic                 at_out;
        logic [POS_WIDTH-1:0] pos;
        logic [POS_WIDTH-1:0] tag_start;
    } front_op_t;

    function automatic logic is_recorded(logic [OPEN_W-1:0] lev, logic [7:0] limit);
        return (limit == 8'd0) || (lev <= OPEN_W'(limit));
    endfunction

endpackage

// ----- rtl/xebs_if.sv -----
interface xebs_byte_if import xebs_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_byte;

    modport source (output valid, char_byte, last_byte, input ready);
    modport sink (input valid, char_byte, last_byte, output ready);
endinterface

interface xebs_event_if import xebs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           event_kind;
    logic [7:0]           nest_level;
    logic [POS_WIDTH-1:0] start_offset;
    logic [POS_WIDTH-1:0] open_tag_len;
    logic [POS_WIDTH-1:0] element_len;
    logic                 done_res;
    logic                 status;

    modport source (output valid, event_kind, nest_level, start_offset, open_tag_len,
                    element_len, done_res, status, input ready);
    modport sink (input valid, event_kind, nest_level, start_offset, open_tag_len,
                  element_len, done_res, status, output ready);
endinterface

// ----- rtl/xebs_front.sv -----
module xebs_front import xebs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    xebs_byte_if.sink        byte_ch,
    input  logic             queue_full,
    output logic             op_push,
    output front_op_t        op
);

    phase_t               phase_reg, phase_next;
    logic [POS_WIDTH-1:0] byte_cnt_reg;
    logic [POS_WIDTH-1:0] tag_start_reg, tag_start_next;
    logic                 opens_reg, opens_next;
    logic                 ps_reg, ps_next;
    logic                 cret_reg, cret_next;
    logic                 do_body;
    logic                 body_opens;
    logic                 body_ps;
    logic [7:0]           c;

    assign c             = byte_ch.char_byte;
    assign byte_ch.ready = !queue_full;
    assign op_push       = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        phase_next     = phase_reg;
        tag_start_next = tag_start_reg;
        opens_next     = opens_reg;
        ps_next        = ps_reg;
        cret_next      = cret_reg;
        do_body        = 1'b0;
        body_opens     = opens_reg;
        body_ps        = ps_reg;
        op             = '0;
        op.pos         = byte_cnt_reg;
        op.tag_start   = tag_start_reg;
        op.last        = byte_ch.last_byte;

        case (phase_reg)
            PH_INIT, PH_OUT:
            begin
                if (c == CH_LT)
                begin
                    tag_start_next = byte_cnt_reg;
                    phase_next     = (phase_reg == PH_INIT) ? PH_INIT_LT : PH_OUT_LT;
                end
            end
            PH_INIT_LT, PH_OUT_LT:
            begin
                if (phase_reg == PH_INIT_LT && (c inside {CH_SLASH, CH_GT}))
                begin
                    op.ferr = 1'b1;
                end
                else if (c == CH_BANG)
                begin
                    cret_next  = (phase_reg == PH_OUT_LT);
                    phase_next = PH_BANG1;
                end
                else if (phase_reg == PH_INIT_LT && c == CH_QUEST)
                begin
                    phase_next = PH_HEADER;
                end
                else
                begin
                    // tag name starts here; this byte also runs through the tag body
                    op.decide  = 1'b1;
                    opens_next = (c != CH_SLASH);
                    body_opens = opens_next;
                    body_ps    = 1'b0;
                    ps_next    = 1'b0;
                    phase_next = PH_TAG;
                    do_body    = 1'b1;
                end
            end
            PH_HEADER:
            begin
                if (c == CH_GT)
                begin
                    phase_next = PH_OUT;
                end
            end
            PH_BANG1:
            begin
                if (c == CH_DASH)
                begin
                    phase_next = PH_BANG2;
                end
                else
                begin
                    op.ferr = 1'b1;
                end
            end
            PH_BANG2:
            begin
                if (c == CH_DASH)
                begin
                    phase_next = PH_COM0;
                end
                else
                begin
                    op.ferr = 1'b1;
                end
            end
            PH_COM0:
            begin
                if (c == CH_DASH)
                begin
                    phase_next = PH_COM1;
                end
            end
            PH_COM1:
            begin
                phase_next = (c == CH_DASH) ? PH_COM2 : PH_COM0;
            end
            PH_COM2:
            begin
                // byte after "--" that is not '>' drops back without being examined
                if (c == CH_GT)
                begin
                    phase_next = cret_reg ? PH_OUT : PH_INIT;
                end
                else
                begin
                    phase_next = PH_COM0;
                end
            end
            PH_TAG:
            begin
                do_body = 1'b1;
            end
            default:
            begin
                phase_next = PH_INIT;
            end
        endcase

        if (do_body)
        begin
            if (c == CH_LT)
            begin
                op.ferr = 1'b1;
            end
            else if (c != CH_GT)
            begin
                ps_next = (c == CH_SLASH);
            end
            else
            begin
                op.gt      = 1'b1;
                op.also    = body_ps;
                ps_next    = 1'b0;
                phase_next = PH_OUT;
            end
        end

        op.opens  = body_opens;
        op.at_out = (phase_next == PH_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INIT;
            byte_cnt_reg  <= '0;
            tag_start_reg <= '0;
            opens_reg     <= 1'b0;
            ps_reg        <= 1'b0;
            cret_reg      <= 1'b0;
        end
        else if (op_push)
        begin
            if (byte_ch.last_byte)
            begin
                phase_reg     <= PH_INIT;
                byte_cnt_reg  <= '0;
                tag_start_reg <= '0;
                opens_reg     <= 1'b0;
                ps_reg        <= 1'b0;
                cret_reg      <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                byte_cnt_reg  <= byte_cnt_reg + POS_WIDTH'(1);
                tag_start_reg <= tag_start_next;
                opens_reg     <= opens_next;
                ps_reg        <= ps_next;
                cret_reg      <= cret_next;
            end
        end
    end

endmodule

// ----- rtl/xebs_fifo.sv -----
module xebs_fifo import xebs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  front_op_t push_op,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output front_op_t head_op
);

    front_op_t             slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/xebs_back.sv -----
module xebs_back import xebs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  level_limit,
    input  logic        op_valid,
    input  front_op_t   op,
    output logic        op_pop,
    xebs_event_if.source event_ch
);

    logic [OPEN_W-1:0]    oc_reg;
    logic                 root_reg;
    logic [DEPTH_W-1:0]   rd_reg;
    logic                 err_seen_reg;
    logic [POS_WIDTH-1:0] stack_reg [STACK_DEPTH];

    logic                 out_valid_reg;
    logic [1:0]           kind_reg;
    logic [7:0]           lev_reg;
    logic [POS_WIDTH-1:0] start_reg;
    logic [POS_WIDTH-1:0] otl_reg;
    logic [POS_WIDTH-1:0] el_reg;
    logic                 done_reg;
    logic                 status_reg;

    logic                 err;
    logic                 push;
    logic                 pop;
    logic                 root_next;
    logic [OPEN_W-1:0]    oc_next;
    logic [OPEN_W-1:0]    lev;
    logic [DEPTH_W-1:0]   rd_m1;
    logic [POS_WIDTH-1:0] top;
    logic [POS_WIDTH-1:0] tlen;
    logic [1:0]           kind;
    logic [POS_WIDTH-1:0] otl;
    logic [POS_WIDTH-1:0] el;
    logic                 has_result;

    assign op_pop = op_valid && (!out_valid_reg || event_ch.ready);
    assign rd_m1  = rd_reg - 1'b1;
    assign tlen   = op.pos - op.tag_start + POS_WIDTH'(1);

    always_comb
    begin
        err       = op.ferr;
        push      = 1'b0;
        pop       = 1'b0;
        root_next = root_reg;
        oc_next   = oc_reg;
        lev       = '0;
        top       = '0;
        kind      = EV_NONE;
        otl       = '0;
        el        = '0;

        if (op.decide)
        begin
            if (op.opens)
            begin
                if (oc_reg == '0)
                begin
                    if (root_reg)
                    begin
                        err = 1'b1;
                    end
                    root_next = 1'b1;
                end
                else if (oc_reg >= OPEN_W'(OPEN_MAX))
                begin
                    err = 1'b1;
                end
                if (is_recorded(oc_reg, level_limit))
                begin
                    if (rd_reg >= DEPTH_W'(STACK_DEPTH))
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                oc_next = oc_reg + 1'b1;
            end
            else if (oc_reg == '0)
            begin
                err = 1'b1;
            end
        end

        if (op.gt)
        begin
            if (oc_next == '0)
            begin
                err = 1'b1;
            end
            else
            begin
                lev = oc_next - 1'b1;
                if (op.opens && !op.also)
                begin
                    if (is_recorded(lev, level_limit))
                    begin
                        kind = EV_OPEN;
                        otl  = tlen;
                    end
                end
                else if (!op.opens && op.also && is_recorded(lev, level_limit))
                begin
                    // "/>" closing an end tag of a recorded element
                    err = 1'b1;
                end
                else
                begin
                    if (is_recorded(lev, level_limit))
                    begin
                        if (rd_reg != '0)
                        begin
                            pop = 1'b1;
                            top = stack_reg[rd_m1[SP_W-1:0]];
                        end
                        kind = op.opens ? EV_SELF_CLOSE : EV_END_TAG;
                        otl  = op.opens ? tlen : '0;
                        el   = op.pos - top + POS_WIDTH'(1);
                    end
                    oc_next = oc_next - 1'b1;
                end
            end
        end

        if (err || kind == EV_NONE)
        begin
            lev = '0;
        end
        has_result = !err_seen_reg && (err || kind != EV_NONE || op.last);
    end

    always_ff @(posedge clk)
    begin
        if (op_pop && !err_seen_reg && !err && !op.last && push)
        begin
            stack_reg[rd_reg[SP_W-1:0]] <= op.tag_start;
        end
        if (op_pop && has_result)
        begin
            kind_reg   <= err ? EV_NONE : kind;
            lev_reg    <= lev[7:0];
            start_reg  <= err ? '0 : (kind == EV_NONE) ? '0
                                   : (kind == EV_OPEN) ? op.tag_start : top;
            otl_reg    <= err ? '0 : otl;
            el_reg     <= err ? '0 : el;
            done_reg   <= err || op.last;
            status_reg <= err || (op.last && !(op.at_out && oc_next == '0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_reg        <= '0;
            root_reg      <= 1'b0;
            rd_reg        <= '0;
            err_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_pop)
            begin
                out_valid_reg <= has_result;
                if (op.last)
                begin
                    oc_reg       <= '0;
                    root_reg     <= 1'b0;
                    rd_reg       <= '0;
                    err_seen_reg <= 1'b0;
                end
                else if (!err_seen_reg)
                begin
                    if (err)
                    begin
                        err_seen_reg <= 1'b1;
                    end
                    else
                    begin
                        oc_reg   <= oc_next;
                        root_reg <= root_next;
                        if (push)
                        begin
                            rd_reg <= rd_reg + 1'b1;
                        end
                        else if (pop)
                        begin
                            rd_reg <= rd_m1;
                        end
                    end
                end
            end
            else if (event_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign event_ch.valid        = out_valid_reg;
    assign event_ch.event_kind   = kind_reg;
    assign event_ch.nest_level   = lev_reg;
    assign event_ch.start_offset = start_reg;
    assign event_ch.open_tag_len = otl_reg;
    assign event_ch.element_len  = el_reg;
    assign event_ch.done_res     = done_reg;
    assign event_ch.status       = status_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("start stack depth past its size");

    a_recorded_subset: assert property (@(posedge clk) disable iff (!rst_n)
        OPEN_W'(rd_reg) <= oc_reg)
        else $error("more recorded starts than open elements");

    a_open_needs_root: assert property (@(posedge clk) disable iff (!rst_n)
        (oc_reg != '0) |-> root_reg)
        else $error("element open without a root");

    a_result_content: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !done_reg) |-> (kind_reg != EV_NONE && !status_reg))
        else $error("result with neither event nor done");

endmodule

// ----- rtl/xml_element_boundary_scanner_core.sv -----
// xml element boundary scanner
// byte_ch takes one document byte per transfer, char_byte plus last_byte on the
// final byte of a document. event_ch carries at most one result per byte: an
// open tag, an element closed by an end tag or a self-closed element with its
// level, start offset, open-tag length and element length, and done_res/status
// on the final byte or on the first error. after an error nothing more comes out
// for that document, also not on the byte marked last_byte, after which the next document starts.
// level_limit is written through level_limit_we/level_limit_wdata; the user must
// write it only between documents or while no byte is in flight, which the block
// itself does not enforce. 0 records every level.
// throughput is one byte per cycle while event_ch does not stall, with one state
// update and at most one push or pop of the start stack per byte. a result passes
// through the two-entry op queue between the classifier and the stack unit and then
// the output register. when event_ch stalls, the output register holds its result,
// the op queue fills, and byte_ch.ready drops once the queue is full.
// reset clears the scan state, counters, queue and output; level_limit
// returns to 0. the start stack needs no clearing.
module xml_element_boundary_scanner_core import xebs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    xebs_byte_if.sink    byte_ch,
    xebs_event_if.source event_ch,
    input  logic         level_limit_we,
    input  logic [7:0]   level_limit_wdata
);

    logic [7:0] level_limit_reg;
    logic       queue_full;
    logic       op_push;
    front_op_t  op_in;
    logic       op_pop;
    logic       head_valid;
    front_op_t  head_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_limit_reg <= '0;
        end
        else if (level_limit_we)
        begin
            level_limit_reg <= level_limit_wdata;
        end
    end

    xebs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .queue_full (queue_full),
        .op_push    (op_push),
        .op         (op_in)
    );

    xebs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (op_push),
        .push_op    (op_in),
        .full       (queue_full),
        .pop        (op_pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    xebs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .level_limit (level_limit_reg),
        .op_valid    (head_valid),
        .op          (head_op),
        .op_pop      (op_pop),
        .event_ch    (event_ch)
    );

endmodule
